@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker file of the parser block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define AIP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, off while reset is high.
`define AIP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// Next-cycle implication that is also checked while reset is high.
`define AIP_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle implication under reset failed");

`endif

@@ rtl/aip_pkg.sv @@
// Package of the ASCII integer parser: types, codes, digit and limit functions.
`timescale 1ns / 1ps
`default_nettype none

package aip_pkg;

   // Base codes, as held in base_mode and in the active base register
   localparam logic [2:0] BASE_AUTO = 3'd0;
   localparam logic [2:0] BASE_NONE = 3'd0;
   localparam logic [2:0] BASE_BIN  = 3'd1;
   localparam logic [2:0] BASE_OCT  = 3'd2;
   localparam logic [2:0] BASE_DEC  = 3'd3;
   localparam logic [2:0] BASE_HEX  = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_BASE_MODE    = 2'd0;
   localparam logic [1:0] CSR_WIDTH_SELECT = 2'd1;
   localparam logic [1:0] CSR_SIGNED_MODE  = 2'd2;

   // Width select codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   // Characters
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_O     = 8'h6f;
   localparam logic [7:0] CHAR_X     = 8'h78;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } item_type;

   typedef struct packed {
      logic [2:0] base_mode;
      logic [1:0] width_select;
      logic       signed_mode;
   } cfg_type;

   typedef struct packed {
      logic [63:0] parsed_value;
      logic        parse_error;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   // Largest magnitude allowed for the selected width and sign mode
   function automatic logic [63:0] limit_of(input logic [1:0] width_select,
                                             input logic signed_mode);
      logic [63:0] lim;
      case (width_select)
         WIDTH_8:  lim = signed_mode ? 64'h80 : 64'hff;
         WIDTH_16: lim = signed_mode ? 64'h8000 : 64'hffff;
         WIDTH_32: lim = signed_mode ? 64'h8000_0000 : 64'hffff_ffff;
         default:  lim = signed_mode ? 64'h8000_0000_0000_0000 : 64'hffff_ffff_ffff_ffff;
      endcase
      return lim;
   endfunction

   // Digit value of a character in the given base, flagged invalid if not a digit
   function automatic digit_type digit_value(input logic [7:0] c, input logic [2:0] code);
      digit_type d;
      logic      is_num;
      logic      is_alpha;
      is_num   = c inside {[8'h30:8'h39]};
      is_alpha = (code == BASE_HEX) && (c inside {[8'h61:8'h66], [8'h41:8'h46]});
      // low nibble of '0'..'9' is the digit; of 'a'..'f' / 'A'..'F' it is the digit - 9
      d.value = is_alpha ? c[3:0] + 4'd9 : c[3:0];
      case (code)
         BASE_BIN: d.valid = is_num && (d.value < 4'd2);
         BASE_OCT: d.valid = is_num && (d.value < 4'd8);
         BASE_DEC: d.valid = is_num;
         BASE_HEX: d.valid = is_num || is_alpha;
         default:  d.valid = 1'b0;
      endcase
      return d;
   endfunction

   // acc * radix + digit by shift and add; 68 bits hold any result
   function automatic logic [67:0] scale_add(input logic [63:0] acc, input logic [2:0] code,
                                             input logic [3:0] digit);
      logic [67:0] a;
      logic [67:0] prod;
      a = {4'd0, acc};
      case (code)
         BASE_BIN: prod = a << 1;
         BASE_OCT: prod = a << 3;
         BASE_DEC: prod = (a << 3) + (a << 1);
         BASE_HEX: prod = a << 4;
         default:  prod = a;
      endcase
      return prod + {64'd0, digit};
   endfunction

   // Base chosen by a prefix letter
   function automatic logic [2:0] prefix_base(input logic [7:0] c);
      logic [2:0] b;
      case (c)
         CHAR_B:  b = BASE_BIN;
         CHAR_O:  b = BASE_OCT;
         CHAR_X:  b = BASE_HEX;
         default: b = BASE_NONE;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

@@ rtl/aip_in_reg.sv @@
// Input register of the parser: holds one character transaction for the step logic.
`timescale 1ns / 1ps
`default_nettype none

module aip_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  aip_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_take,
   output aip_pkg::item_type out_item
);
   import aip_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign in_ready  = !valid_ff || out_take;
   assign valid_in  = in_valid || (valid_ff && !out_take);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

@@ rtl/aip_step.sv @@
// String state of the parser and the per-character update and final result logic.
`timescale 1ns / 1ps
`default_nettype none

module aip_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  aip_pkg::item_type   item,
   input  aip_pkg::cfg_type    cfg,
   output aip_pkg::result_type result
);
   import aip_pkg::*;

   logic [63:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   logic [2:0]  base_ff, base_in;
   logic        neg_ff, neg_in;
   logic        sticky_ff, sticky_in;
   logic        pending_ff, pending_in;

   logic [63:0] limit;
   logic        first;
   logic [2:0]  cur_base;
   logic [2:0]  eff_base;
   digit_type   dig;
   logic [67:0] scaled;
   logic        is_prefix;
   logic        fin_err;

   always_comb begin
      limit = limit_of(cfg.width_select, cfg.signed_mode);
      first = (pos_ff == 2'd0);
      if (!first) begin
         cur_base = base_ff;
      end else if (cfg.signed_mode || cfg.base_mode == BASE_AUTO) begin
         cur_base = BASE_DEC;
      end else if (cfg.base_mode <= BASE_HEX) begin
         cur_base = cfg.base_mode;
      end else begin
         cur_base = BASE_NONE;
      end
      eff_base  = cfg.signed_mode ? BASE_DEC : cur_base;
      dig       = digit_value(item.char_code, eff_base);
      scaled    = scale_add(acc_ff, eff_base, dig.value);
      is_prefix = (item.char_code == CHAR_B) || (item.char_code == CHAR_O) ||
                  (item.char_code == CHAR_X);

      acc_in     = acc_ff;
      base_in    = cur_base;
      neg_in     = neg_ff;
      sticky_in  = sticky_ff;
      pending_in = pending_ff;
      if (!sticky_ff) begin
         if (cfg.signed_mode && first && item.char_code == CHAR_MINUS) begin
            neg_in = 1'b1;
         end else if (!cfg.signed_mode && cfg.base_mode == BASE_AUTO && pos_ff == 2'd1 &&
                      pending_ff && acc_ff == 64'd0 && cur_base == BASE_DEC &&
                      is_prefix) begin
            // leading '0' then prefix letter: switch base, demand a digit
            base_in    = prefix_base(item.char_code);
            pending_in = 1'b0;
         end else if (!dig.valid) begin
            sticky_in = 1'b1;
         end else if (scaled > {4'd0, limit}) begin
            sticky_in = 1'b1;
         end else begin
            acc_in     = scaled[63:0];
            pending_in = 1'b1;
         end
      end
      pos_in = (pos_ff == 2'd3) ? pos_ff : pos_ff + 2'd1;

      fin_err = sticky_in || !pending_in || (acc_in > limit) ||
                (cfg.signed_mode && neg_in && acc_in == 64'd0) ||
                (cfg.signed_mode && !neg_in && acc_in == limit);
      result.parse_error  = fin_err;
      result.parsed_value = fin_err ? 64'd0 :
                            (cfg.signed_mode && neg_in) ? 64'd0 - acc_in : acc_in;

      // drop the string state once its result is out
      if (item.last_char) begin
         acc_in     = 64'd0;
         pos_in     = 2'd0;
         base_in    = BASE_DEC;
         neg_in     = 1'b0;
         sticky_in  = 1'b0;
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= 64'd0;
         pos_ff     <= 2'd0;
         base_ff    <= BASE_DEC;
         neg_ff     <= 1'b0;
         sticky_ff  <= 1'b0;
         pending_ff <= 1'b0;
      end else if (step_en) begin
         acc_ff     <= acc_in;
         pos_ff     <= pos_in;
         base_ff    <= base_in;
         neg_ff     <= neg_in;
         sticky_ff  <= sticky_in;
         pending_ff <= pending_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ascii_integer_parser.sv @@
// Top level of the ASCII integer parser: channels, configuration registers, result register.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  req     | req_valid/ready, req_char_code, req_last_char | in
//  rsp     | rsp_valid/ready, rsp_parsed_value, rsp_parse_error | out
//  csr     | csr_valid/ready, csr_index, csr_wdata        | in
//
// One character per clock cycle while no result stalls. A character is held in
// the input register; the step logic consumes it there and, on the last
// character, loads the result register, from which rsp presents the result.
// The step is one shift-add by the radix and a compare against the width
// limit. Synchronous reset clears the string state, the channel valids and
// the configuration (auto base, 64 bits, unsigned).
// A stalled result holds only a last character in the input register; other
// characters keep flowing. csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module ascii_integer_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_parsed_value,
   output logic        rsp_parse_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import aip_pkg::*;

   // configuration registers
   cfg_type    cfg_ff;
   cfg_type    cfg_in;

   // input stage
   item_type   req_item;
   item_type   s1_item;
   logic       s1_valid;
   logic       s1_take;

   // step result and output register
   result_type step_result;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_load;
   result_type rsp_ff;

   assign csr_ready = 1'b1;

   // apply a configuration write; an index past the list is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BASE_MODE:    cfg_in.base_mode    = csr_wdata[2:0];
            CSR_WIDTH_SELECT: cfg_in.width_select = csr_wdata[1:0];
            CSR_SIGNED_MODE:  cfg_in.signed_mode  = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_mode    <= BASE_AUTO;
         cfg_ff.width_select <= WIDTH_64;
         cfg_ff.signed_mode  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item.char_code = req_char_code;
   assign req_item.last_char = req_last_char;

   aip_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (s1_valid),
      .out_take  (s1_take),
      .out_item  (s1_item)
   );

   // a last character needs room in the result register; others always advance
   assign s1_take  = s1_valid && (!s1_item.last_char || !rsp_valid_ff || rsp_ready);
   assign rsp_load = s1_take && s1_item.last_char;

   aip_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (s1_take),
      .item    (s1_item),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = rsp_ff.parsed_value;
   assign rsp_parse_error  = rsp_ff.parse_error;

endmodule

`default_nettype wire

@@ rtl/aip_checker.sv @@
// Port-level checker of the ASCII integer parser and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aip_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_parsed_value,
   input logic        rsp_parse_error
);

   // a stalled result transaction stays valid
   `AIP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // an errored result always carries a zero value
   `AIP_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_parse_error, rsp_parsed_value == 64'd0)

   // a signed or unsigned value of all ones can only come from a valid parse
   `AIP_ASSERT_IMP(a_ones_ok, clock, reset, rsp_valid && (&rsp_parsed_value), !rsp_parse_error)

   // reset drops any pending result
   `AIP_ASSERT_NXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid)

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_parsed_value (rsp_parsed_value),
   .rsp_parse_error  (rsp_parse_error)
);

`default_nettype wire

@@ sim/ascii_integer_parser_checker.sv @@
// Result checker for the ASCII integer parser: tracks configuration, predicts and compares results.
`timescale 1ns / 1ps

module ascii_integer_parser_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_parsed_value,
   input  logic        rsp_parse_error,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          error_count,
   output int          outstanding
);
   import aip_pkg::*;

   // configuration mirror
   logic [2:0]  base_mode_r;
   logic [1:0]  width_sel_r;
   logic        signed_r;

   // per-string parse state
   logic [63:0] acc;
   logic [1:0]  pos;
   logic [2:0]  abase;
   logic        neg;
   logic        sticky;
   logic        pend;

   result_type  parsed_results[$];
   result_type  head;

   function automatic logic [63:0] magnitude_limit(input logic [1:0] ws, input logic sgn);
      int unsigned bits;
      bits = 8 << ws;
      // a shift by 64 yields zero, so the unsigned 64-bit limit wraps to all ones
      if (sgn) return 64'd1 << (bits - 1);
      return (64'd1 << bits) - 64'd1;
   endfunction

   function automatic int radix_of_base(input logic [2:0] code);
      case (code)
         BASE_BIN: return 2;
         BASE_OCT: return 8;
         BASE_DEC: return 10;
         BASE_HEX: return 16;
         default:  return 0;
      endcase
   endfunction

   function automatic int digit_in_base(input logic [7:0] c, input logic [2:0] code);
      int v;
      v = -1;
      if (c >= "0" && c <= "9") v = int'(c) - int'("0");
      else if (code == BASE_HEX && c >= "a" && c <= "f") v = int'(c) - int'("a") + 10;
      else if (code == BASE_HEX && c >= "A" && c <= "F") v = int'(c) - int'("A") + 10;
      if (v < 0 || v >= radix_of_base(code)) return -1;
      return v;
   endfunction

   task automatic clear_string();
      acc    = '0;
      pos    = '0;
      abase  = BASE_DEC;
      neg    = 1'b0;
      sticky = 1'b0;
      pend   = 1'b0;
   endtask

   task automatic parse_char(input logic [7:0] c, input logic last);
      logic [63:0] lim;
      logic [63:0] r;
      logic [63:0] value;
      logic [2:0]  eff;
      logic        bad;
      int          d;
      lim = magnitude_limit(width_sel_r, signed_r);
      if (pos == 2'd0) begin
         if (signed_r || base_mode_r == BASE_AUTO) abase = BASE_DEC;
         else abase = (base_mode_r <= BASE_HEX) ? base_mode_r : BASE_NONE;
      end
      eff = signed_r ? BASE_DEC : abase;
      if (!sticky) begin
         if (signed_r && pos == 2'd0 && c == CHAR_MINUS) begin
            neg = 1'b1;
         end else if (!signed_r && base_mode_r == BASE_AUTO && pos == 2'd1 && pend &&
                      acc == 64'd0 && abase == BASE_DEC &&
                      (c == CHAR_B || c == CHAR_O || c == CHAR_X)) begin
            abase = (c == CHAR_B) ? BASE_BIN : (c == CHAR_O) ? BASE_OCT : BASE_HEX;
            pend  = 1'b0;
         end else begin
            d = digit_in_base(c, eff);
            if (d < 0) begin
               sticky = 1'b1;
            end else begin
               r = 64'(radix_of_base(eff));
               // refuse any step that would pass the limit; never wrap
               if (acc > (lim - 64'(d)) / r) sticky = 1'b1;
               else begin
                  acc  = acc * r + 64'(d);
                  pend = 1'b1;
               end
            end
         end
      end
      if (pos != 2'd3) pos = pos + 2'd1;
      if (last) begin
         bad = sticky || !pend || acc > lim;
         if (!bad && signed_r && ((neg && acc == 64'd0) || (!neg && acc == lim))) bad = 1'b1;
         if (bad) value = '0;
         else if (signed_r && neg) value = 64'd0 - acc;
         else value = acc;
         parsed_results.push_back('{parsed_value: value, parse_error: bad});
         clear_string();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         base_mode_r = BASE_AUTO;
         width_sel_r = WIDTH_64;
         signed_r    = 1'b0;
         clear_string();
         parsed_results.delete();
         error_count = 0;
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_MODE:    base_mode_r = csr_wdata[2:0];
               CSR_WIDTH_SELECT: width_sel_r = csr_wdata[1:0];
               CSR_SIGNED_MODE:  signed_r    = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) parse_char(req_char_code, req_last_char);
         if (rsp_valid && rsp_ready) begin
            if (parsed_results.size() == 0) begin
               report_mismatch("result with none pending", '0, rsp_parsed_value);
            end else begin
               head = parsed_results.pop_front();
               if (rsp_parsed_value !== head.parsed_value)
                  report_mismatch("parsed_value", head.parsed_value, rsp_parsed_value);
               if (rsp_parse_error !== head.parse_error)
                  report_mismatch("parse_error", 64'(head.parse_error), 64'(rsp_parse_error));
            end
         end
         outstanding <= parsed_results.size();
      end
   end

endmodule

@@ sim/ascii_integer_parser_tb.sv @@
// Testbench top for the ASCII integer parser: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module ascii_integer_parser_tb;
   import aip_pkg::*;

   localparam int TIMEOUT_CYCLES   = 200000;
   localparam int RANDOM_CHARS     = 750;
   localparam int LONG_HOLD_CYCLES = 300;
   // a last character passes the input register and the result register before its result shows up
   localparam int DRAIN_CYCLES     = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = '0;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_parsed_value;
   logic        rsp_parse_error;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   int          error_count;
   int          outstanding;
   int          chars_sent = 0;
   int          cycle_count = 0;

   // flow-control knobs of the sender and receiver processes
   bit          sender_gaps = 1'b1;
   bit          receiver_gaps = 1'b1;
   bit          long_hold = 1'b0;

   // configuration as last written, used to shape well-formed strings
   logic [2:0]  cur_base = BASE_AUTO;
   logic [1:0]  cur_width = WIDTH_64;
   logic        cur_signed = 1'b0;

   // characters of the string being sent
   logic [7:0]  text[$];

   always #5 clock = ~clock;

   ascii_integer_parser uut (.*);

   ascii_integer_parser_checker result_check (.*);

   // Offer one character. Hold valid across back-to-back transactions; drop it
   // only for a random gap, so valid is never lowered and raised in one step.
   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
   endtask

   // Send the current string, marking its final character as last.
   task automatic send_text();
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic load_text(input string s);
      text.delete();
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endtask

   // Pause the sender until every pending result has come out, then let the
   // pipeline settle so that the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; valid stays up so writes can run back to back.
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Reprogram all registers while idle; junk fills the unused upper data bits.
   task automatic configure(input logic [2:0] base, input logic [1:0] width,
                            input logic sgn, input logic [7:0] junk);
      drain();
      write_reg(CSR_BASE_MODE, {junk[7:3], base});
      write_reg(CSR_WIDTH_SELECT, {junk[7:2], width});
      write_reg(CSR_SIGNED_MODE, {junk[7:1], sgn});
      csr_valid  <= 1'b0;
      cur_base   = base;
      cur_width  = width;
      cur_signed = sgn;
   endtask

   // Build one random string. Most are numbers written in the base that the
   // current configuration expects, with values clustered at the width limits;
   // the rest are corrupted numbers, bare prefixes or signs, and raw noise.
   task automatic build_string();
      logic [63:0] lim;
      logic [63:0] mask;
      logic [63:0] value;
      logic [63:0] v;
      logic [7:0]  letter;
      logic [7:0]  digits[$];
      int          kind;
      int          radix;
      int          dgt;
      int          spot;
      string       specials;
      specials = "-boxBOX09afAFgG ";
      kind = $urandom_range(0, 19);
      text.delete();
      if (kind >= 18) begin
         repeat ($urandom_range(1, 5)) text.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if (kind == 17) begin
         case ($urandom_range(0, 7))
            0: load_text("0x");
            1: load_text("0b");
            2: load_text("0o");
            3: load_text("-");
            4: load_text("0X");
            5: load_text("1x");
            6: load_text("-0");
            default: load_text("0x-1");
         endcase
         return;
      end
      letter = 8'd0;
      radix  = 10;
      if (cur_signed) begin
         lim  = 64'd1 << ((8 << cur_width) - 1);
         mask = (lim << 1) - 64'd1;
      end else begin
         lim  = (64'd1 << (8 << cur_width)) - 64'd1;
         mask = lim;
         case (cur_base)
            BASE_BIN: radix = 2;
            BASE_OCT: radix = 8;
            BASE_HEX: radix = 16;
            BASE_AUTO: begin
               // pick a prefix, or none for plain decimal
               case ($urandom_range(0, 3))
                  1: begin radix = 2;  letter = CHAR_B; end
                  2: begin radix = 8;  letter = CHAR_O; end
                  3: begin radix = 16; letter = CHAR_X; end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      case ($urandom_range(0, 7))
         0: value = '0;
         1: value = lim;
         2: value = lim + 64'd1;
         3: value = lim - 64'd1;
         4: value = 64'($urandom_range(0, 20));
         default: value = ({$urandom, $urandom} & mask) >> $urandom_range(0, 63);
      endcase
      if (cur_signed && $urandom_range(0, 1)) text.push_back(CHAR_MINUS);
      if (letter != 8'd0) begin
         text.push_back("0");
         text.push_back(letter);
      end
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) text.push_back("0");
      v = value;
      do begin
         dgt = int'(v % 64'(radix));
         v   = v / 64'(radix);
         if (dgt < 10) digits.push_front(8'(int'("0") + dgt));
         else digits.push_front(8'(($urandom_range(0, 1) ? int'("a") : int'("A")) + dgt - 10));
      end while (v != 0);
      // an extra trailing digit pushes values near the limit into overflow
      if ($urandom_range(0, 7) == 0) digits.push_back("1");
      text = {text, digits};
      if (kind >= 14) begin
         spot = $urandom_range(0, text.size() - 1);
         if (kind == 14) text[spot] = 8'($urandom_range(0, 255));
         else text[spot] = specials[$urandom_range(0, specials.len() - 1)];
      end
   endtask

   // Receiver: draw a short stall per result, toggle stretches without stalls,
   // and on request hold off for a long time so the block backs up.
   initial begin
      int wait_cycles;
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         if ($urandom_range(0, 9) == 0) receiver_gaps = !receiver_gaps;
         wait_cycles = receiver_gaps ? $urandom_range(0, 3) : 0;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Main stimulus.
   initial begin
      string unsigned_cases[];
      string signed_cases[];
      int    directed_chars;
      unsigned_cases = {"0", "9", "0x", "0xf", "0B1", "1b", "-"};
      signed_cases   = {"-128", "128", "-0", "-", "1-", "127"};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first under the reset configuration: auto base, 64 bits,
      // unsigned. Cover bare prefix, upper-case prefix letter, prefix letter
      // not after a leading zero, minus in unsigned mode, a non-ASCII byte and a NUL byte.
      foreach (unsigned_cases[i]) begin
         load_text(unsigned_cases[i]);
         send_text();
      end
      send_char(8'hff, 1'b1);
      send_char(8'h00, 1'b1);

      // Signed 8-bit: most negative value, positive overflow by one, minus
      // zero, sign alone, misplaced sign and the largest positive value.
      configure(BASE_DEC, WIDTH_8, 1'b1, 8'h00);
      foreach (signed_cases[i]) begin
         load_text(signed_cases[i]);
         send_text();
      end

      // Random part: each phase drains the block, reprograms it and sends a
      // batch of strings. The early phases walk every base code, including the
      // reserved ones, and all widths; every third phase runs signed.
      directed_chars = chars_sent;
      for (int phase = 0; chars_sent < directed_chars + RANDOM_CHARS; phase++) begin
         configure(phase < 8 ? 3'(phase) : 3'($urandom_range(0, 7)), 2'(phase % 4),
                   phase % 3 == 2, 8'($urandom));
         // hold the receiver off once while the sender keeps pushing
         if (phase == 1) long_hold = 1'b1;
         repeat ($urandom_range(8, 20)) begin
            if (chars_sent >= directed_chars + RANDOM_CHARS) break;
            sender_gaps = ($urandom_range(0, 4) != 0);
            build_string();
            send_text();
         end
      end

      drain();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
